// ===== design/color_vision_deficiency_pixel_top_defines.svh =====
// Assertion macros for the color vision deficiency pixel block.
`ifndef COLOR_VISION_DEFICIENCY_PIXEL_TOP_DEFINES_SVH
`define COLOR_VISION_DEFICIENCY_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define CVD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define CVD_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cvd_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, mixing coefficients and sRGB table builders.
package cvd_pkg;

  localparam int LINEAR_BITS_DEF = 16;
  localparam int COLOR_BITS      = 8;
  localparam int CHANNELS        = 3;
  localparam int NUM_CODES       = 256;
  localparam int COEF_BITS       = 16;
  localparam int COEF_FRAC       = 14;
  localparam int ROUND_HALF      = 1 << (COEF_FRAC - 1);

  // Q30 working format of the table builders
  localparam int Q_FRAC = 30;
  localparam longint unsigned Q_ONE  = 64'd1 << Q_FRAC;
  localparam longint unsigned Q_HALF = 64'd1 << (Q_FRAC - 1);

  typedef enum logic [1:0] {
    MODE_ORIGINAL = 2'd0,
    MODE_PROTAN   = 2'd1,
    MODE_DEUTAN   = 2'd2,
    MODE_TRITAN   = 2'd3
  } mode_t;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  // Side data that rides along the whole pipe; rgb[0] is red
  typedef struct packed {
    mode_t                                mode;
    logic [CHANNELS-1:0][COLOR_BITS-1:0]  rgb;
    logic [COLOR_BITS-1:0]                alpha;
  } pix_side_t;

  // Q2.14 matrices, element index row*3+col, listed from index 8 down to 0
  localparam logic [8:0][COEF_BITS-1:0] COEF_PROTAN = {
    16'sd17236, -16'sd788,  -16'sd64,
    16'sd1626,  16'sd12882, 16'sd1876,
    -16'sd3357, 16'sd17246, 16'sd2495
  };
  localparam logic [8:0][COEF_BITS-1:0] COEF_DEUTAN = {
    16'sd15874, 16'sd704,   -16'sd194,
    16'sd777,   16'sd11018, 16'sd4589,
    -16'sd3735, 16'sd14101, 16'sd6018
  };
  localparam logic [8:0][COEF_BITS-1:0] COEF_TRITAN = {
    16'sd4979,  16'sd11327, 16'sd78,
    16'sd2418,  16'sd15250, -16'sd1285,
    -16'sd2929, -16'sd1257, 16'sd20571
  };

  // Coefficient for one matrix element; pass-through mode uses zeros
  function automatic coef_t mix_coef(mode_t m, int row, int col);
    logic [3:0] idx;
    idx = 4'(row * 3 + col);
    case (m)
      MODE_PROTAN: return coef_t'(COEF_PROTAN[idx]);
      MODE_DEUTAN: return coef_t'(COEF_DEUTAN[idx]);
      MODE_TRITAN: return coef_t'(COEF_TRITAN[idx]);
      default:     return '0;
    endcase
  endfunction

  // r^5 in Q30 from four truncating products (elaboration only)
  function automatic longint unsigned fifth_power(longint unsigned r);
    longint unsigned p;
    int n;
    p = r;
    for (n = 0; n < 4; n++) p = (p * r) >> Q_FRAC;
    return p;
  endfunction

  // sRGB-to-linear curve in Q30 at num/255, or num/510 when half is set
  function automatic longint unsigned curve_q30(longint unsigned num, bit half);
    longint unsigned a, b, lo, hi, mid;
    int it;
    if (half) begin
      if (num * 100000 <= 4045 * 510)
        return (num * 200 * Q_ONE + 1292 * 510) / (2 * 1292 * 510);
      a = ((1000 * num + 55 * 510) * 2 * Q_ONE + 1055 * 510) / (2 * 1055 * 510);
    end else begin
      if (num * 100000 <= 4045 * 255)
        return (num * 200 * Q_ONE + 1292 * 255) / (2 * 1292 * 255);
      a = ((1000 * num + 55 * 255) * 2 * Q_ONE + 1055 * 255) / (2 * 1055 * 255);
    end
    b  = (a * a + Q_HALF) >> Q_FRAC;
    lo = 0;
    hi = Q_ONE;
    // largest r with r^5 <= b, binary search
    for (it = 0; it < 32; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (fifth_power(mid) <= b) lo = mid;
        else hi = mid - 1;
      end
    end
    return (b * lo + Q_HALF) >> Q_FRAC;
  endfunction

  // Decode table entry: linear light for 8-bit code idx
  function automatic longint unsigned dec_entry(int idx, int lb);
    longint unsigned top;
    top = (64'd1 << lb) - 64'd1;
    return (curve_q30(longint'(idx), 1'b0) * top + Q_HALF) >> Q_FRAC;
  endfunction

  // Encode threshold: smallest linear value that maps to code k or above
  function automatic longint unsigned thr_entry(int k, int lb);
    longint unsigned top;
    top = (64'd1 << lb) - 64'd1;
    if (k == 0) return 64'd0;
    return (curve_q30(longint'(2 * k - 1), 1'b1) * top + Q_ONE - 64'd1) >> Q_FRAC;
  endfunction

endpackage

// ===== design/cvd_pixel_if.sv =====
`timescale 1ns / 1ps
// Interface: input pixel word channel.
interface cvd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

// ===== design/cvd_result_if.sv =====
`timescale 1ns / 1ps
// Interface: result pixel word channel.
interface cvd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

// ===== design/cvd_cfg_if.sv =====
`timescale 1ns / 1ps
// Interface: mode register write channel.
interface cvd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

// ===== design/cvd_decode.sv =====
`timescale 1ns / 1ps
// Decode stage: sRGB codes to linear light through a constant table.
module cvd_decode import cvd_pkg::*; #(
  parameter int LINEAR_BITS = LINEAR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  pix_side_t                           up_side,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output pix_side_t                           dn_side,
  output logic [CHANNELS-1:0][LINEAR_BITS-1:0] dn_lin
);

  // decode table, built at elaboration
  logic [LINEAR_BITS-1:0] dec_tab [NUM_CODES];

  for (genvar gi = 0; gi < NUM_CODES; gi++) begin : g_dec
    localparam logic [LINEAR_BITS-1:0] ENTRY = LINEAR_BITS'(dec_entry(gi, LINEAR_BITS));
    assign dec_tab[gi] = ENTRY;
  end

  assign up_ready = !dn_valid || dn_ready;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // payload: three table reads
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_side <= up_side;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        dn_lin[ch] <= dec_tab[up_side.rgb[ch]];
      end
    end
  end

endmodule

// ===== design/cvd_mix.sv =====
`timescale 1ns / 1ps
// Mix stages: 3x3 matrix multiply, then row sums rounded and clamped.
module cvd_mix import cvd_pkg::*; #(
  parameter int LINEAR_BITS = LINEAR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  pix_side_t                           up_side,
  input  logic [CHANNELS-1:0][LINEAR_BITS-1:0] up_lin,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output pix_side_t                           dn_side,
  output logic [CHANNELS-1:0][LINEAR_BITS-1:0] dn_lin
);

  localparam int PW = LINEAR_BITS + COEF_BITS + 1;  // one product
  localparam int SW = PW + 2;                       // sum of three

  logic                 prod_valid;
  logic                 prod_ready;
  pix_side_t            prod_side;
  logic signed [PW-1:0] prod      [CHANNELS][CHANNELS];
  logic signed [PW-1:0] prod_next [CHANNELS][CHANNELS];

  logic signed [SW-1:0]                  acc [CHANNELS];
  logic signed [SW-1:0]                  rnd [CHANNELS];
  logic [CHANNELS-1:0][LINEAR_BITS-1:0]  lin_next;

  assign prod_ready = !dn_valid || dn_ready;
  assign up_ready   = !prod_valid || prod_ready;

  // products, one multiplier per matrix element
  always_comb begin
    for (int r = 0; r < CHANNELS; r++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prod_next[r][c] = PW'(mix_coef(up_side.mode, r, c)) *
                          PW'($signed({1'b0, up_lin[c]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (up_ready) begin
      prod_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_side <= up_side;
      prod      <= prod_next;
    end
  end

  // row sum, round half up by 2^14, clamp to zero and to full scale
  always_comb begin
    for (int r = 0; r < CHANNELS; r++) begin
      acc[r] = SW'(prod[r][0]) + SW'(prod[r][1]) + SW'(prod[r][2]);
      rnd[r] = (acc[r] + SW'(ROUND_HALF)) >>> COEF_FRAC;
      if (acc[r][SW-1] || acc[r] == '0) begin
        lin_next[r] = '0;
      end else if (rnd[r][SW-1:LINEAR_BITS] != '0) begin
        lin_next[r] = '1;
      end else begin
        lin_next[r] = rnd[r][LINEAR_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (prod_ready) begin
      dn_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      dn_side <= prod_side;
      dn_lin  <= lin_next;
    end
  end

endmodule

// ===== design/cvd_encode.sv =====
`timescale 1ns / 1ps
// Encode stages: linear light back to 8-bit sRGB, one code bit per stage.
module cvd_encode import cvd_pkg::*; #(
  parameter int LINEAR_BITS = LINEAR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  pix_side_t                           up_side,
  input  logic [CHANNELS-1:0][LINEAR_BITS-1:0] up_lin,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output pix_side_t                           dn_side,
  output logic [CHANNELS-1:0][COLOR_BITS-1:0]  dn_code
);

  localparam int STAGES = COLOR_BITS;

  // encode thresholds, entry k is the lowest linear value for code k
  logic [LINEAR_BITS-1:0] thr_tab [NUM_CODES];

  for (genvar gk = 0; gk < NUM_CODES; gk++) begin : g_thr
    localparam logic [LINEAR_BITS-1:0] ENTRY = LINEAR_BITS'(thr_entry(gk, LINEAR_BITS));
    assign thr_tab[gk] = ENTRY;
  end

  // stage registers; lin is dropped after the last search step needs it
  logic                                  vld  [STAGES];
  pix_side_t                             side [STAGES];
  logic [CHANNELS-1:0][COLOR_BITS-1:0]   code [STAGES];
  logic [CHANNELS-1:0][LINEAR_BITS-1:0]  lin  [STAGES-1];
  wire  [STAGES:0]                       rdy;

  assign rdy[STAGES] = dn_ready;
  assign up_ready    = rdy[0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [COLOR_BITS-1:0] STEP_BIT = COLOR_BITS'(1) << (COLOR_BITS - 1 - s);

    logic                                  src_vld;
    pix_side_t                             src_side;
    logic [CHANNELS-1:0][COLOR_BITS-1:0]   src_code;
    logic [CHANNELS-1:0][LINEAR_BITS-1:0]  src_lin;
    logic [CHANNELS-1:0][COLOR_BITS-1:0]   cand;
    logic [CHANNELS-1:0][COLOR_BITS-1:0]   code_next;

    if (s == 0) begin : g_first
      assign src_vld  = up_valid;
      assign src_side = up_side;
      assign src_code = '0;
      assign src_lin  = up_lin;
    end else begin : g_rest
      assign src_vld  = vld[s-1];
      assign src_side = side[s-1];
      assign src_code = code[s-1];
      assign src_lin  = lin[s-1];
    end

    assign rdy[s] = !vld[s] || rdy[s+1];

    // try setting this bit; keep it if its threshold is reached
    always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        cand[ch] = src_code[ch] | STEP_BIT;
        if (thr_tab[cand[ch]] <= src_lin[ch]) begin
          code_next[ch] = cand[ch];
        end else begin
          code_next[ch] = src_code[ch];
        end
      end
      // pass-through mode picks the original codes at the last step
      if (s == STAGES - 1 && src_side.mode == MODE_ORIGINAL) begin
        code_next = src_side.rgb;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && src_vld) begin
        side[s] <= src_side;
        code[s] <= code_next;
      end
    end

    if (s < STAGES - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (rdy[s] && src_vld) begin
          lin[s] <= src_lin;
        end
      end
    end
  end

  assign dn_valid = vld[STAGES-1];
  assign dn_side  = side[STAGES-1];
  assign dn_code  = code[STAGES-1];

endmodule

// ===== design/color_vision_deficiency_pixel_top.sv =====
`timescale 1ns / 1ps
// Top level: color vision deficiency simulation, one RGBA pixel per word.
//
//   Channel  Side    Word fields                               Handshake
//   pixel    sink    red_in, green_in, blue_in, alpha_in       valid/ready
//   result   source  red_out, green_out, blue_out, alpha_out   valid/ready
//   cfg      sink    mode                                      valid/ready, ready held high
//
// One pixel per cycle sustained while the result side is ready; stages: one decode
// table stage, two mix stages (products, then sum/round/clamp), eight encode stages
// that each settle one bit of the output code by a threshold table compare.
// rst is synchronous: it clears all valid bits and sets mode to pass-through.
// Each stage moves when the one after it is empty or moving, so bubbles close
// up under a stall and no word is lost or repeated.
module color_vision_deficiency_pixel_top import cvd_pkg::*; #(
  parameter int LINEAR_BITS = LINEAR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  cvd_pixel_if.sink      pixel,
  cvd_result_if.source   result,
  cvd_cfg_if.sink        cfg
);

  mode_t mode;

  pix_side_t                             in_side;
  logic                                  dec_valid;
  logic                                  dec_ready;
  pix_side_t                             dec_side;
  logic [CHANNELS-1:0][LINEAR_BITS-1:0]  dec_lin;
  logic                                  mix_valid;
  logic                                  mix_ready;
  pix_side_t                             mix_side;
  logic [CHANNELS-1:0][LINEAR_BITS-1:0]  mix_lin;
  pix_side_t                             enc_side;
  logic [CHANNELS-1:0][COLOR_BITS-1:0]   enc_code;

  // mode register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ORIGINAL;
    end else if (cfg.valid && cfg.ready) begin
      mode <= mode_t'(cfg.mode);
    end
  end

  // mode travels with each pixel
  assign in_side.mode  = mode;
  assign in_side.rgb   = {pixel.blue_in, pixel.green_in, pixel.red_in};
  assign in_side.alpha = pixel.alpha_in;

  cvd_decode #(.LINEAR_BITS(LINEAR_BITS)) u_decode (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pixel.valid),
    .up_ready (pixel.ready),
    .up_side  (in_side),
    .dn_valid (dec_valid),
    .dn_ready (dec_ready),
    .dn_side  (dec_side),
    .dn_lin   (dec_lin)
  );

  cvd_mix #(.LINEAR_BITS(LINEAR_BITS)) u_mix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_side  (dec_side),
    .up_lin   (dec_lin),
    .dn_valid (mix_valid),
    .dn_ready (mix_ready),
    .dn_side  (mix_side),
    .dn_lin   (mix_lin)
  );

  cvd_encode #(.LINEAR_BITS(LINEAR_BITS)) u_encode (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mix_valid),
    .up_ready (mix_ready),
    .up_side  (mix_side),
    .up_lin   (mix_lin),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .dn_side  (enc_side),
    .dn_code  (enc_code)
  );

  assign result.red_out   = enc_code[0];
  assign result.green_out = enc_code[1];
  assign result.blue_out  = enc_code[2];
  assign result.alpha_out = enc_side.alpha;

endmodule

// ===== design/cvd_checker.sv =====
`timescale 1ns / 1ps
// Checker: port-level properties of the top level, attached by bind.
`include "color_vision_deficiency_pixel_top_defines.svh"

module cvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        pix_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_word
);

  // reset empties the whole pipe
  `CVD_ASSERT_NEXT(a_reset_empties, clk, rst, !res_valid, "result valid after reset")

  // with the last stage free or draining, the pipe must take a word
  `CVD_ASSERT_IMPL(a_ready_when_free, clk, rst, !res_valid || res_ready, pix_ready, "input stalled with free pipe")

  // a stalled result word holds
  `CVD_ASSERT_NEXT(a_result_holds, clk, !rst && res_valid && !res_ready, res_valid && $stable(res_word), "stalled result changed")

endmodule

bind color_vision_deficiency_pixel_top cvd_checker u_cvd_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pixel.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_word  ({result.alpha_out, result.blue_out, result.green_out, result.red_out})
);

// ===== bench/color_vision_deficiency_pixel_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench: color vision deficiency pixel block, random and directed words, scoreboard check.
module color_vision_deficiency_pixel_top_tb;
  import cvd_pkg::*;

  localparam int  IDLE_PCT     = 12;
  localparam int  HOLD_CYCLES  = 120;
  localparam int  HOLD_EVERY   = 700;
  localparam int  DRAIN_CYCLES = 30;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  PHASE_WORDS  = 250;
  localparam longint unsigned LIN_MAX = 64'd65535;

  typedef enum logic {WORD_PIXEL, WORD_MODE} word_kind_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    word_kind_t kind;
    mode_t      mode;
    rgba_t      pix;
  } stim_word_t;

  logic clk;
  logic rst;

  cvd_pixel_if  pix_if ();
  cvd_result_if res_if ();
  cvd_cfg_if    cfg_if ();

  color_vision_deficiency_pixel_top dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // Q2.14 mixing weights per mode, [mode][row][col]; pass-through matrix unused
  int mix_w [4][3][3] = '{
    '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}},
    '{'{2495, 17246, -3357}, '{1876, 12882, 1626}, '{-64, -788, 17236}},
    '{'{6018, 14101, -3735}, '{4589, 11018, 777}, '{-194, 704, 15874}},
    '{'{20571, -1257, -2929}, '{-1285, 15250, 2418}, '{78, 11327, 4979}}
  };

  longint unsigned dec_lin [256];
  longint unsigned enc_thr [256];

  stim_word_t pending_words [$];
  rgba_t      expected_pixels [$];

  mode_t cur_mode;
  logic  pix_fire;
  logic  cfg_fire;
  int    pix_accepted;
  int    err_count;
  int    cycles;
  int    hold_left;
  int    next_hold;

  // r^5 in Q30, four truncating products
  function automatic longint unsigned q30_pow5(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int n = 0; n < 4; n++) p = (p * r) >> 30;
    return p;
  endfunction

  // sRGB to linear curve at num/den, Q30
  function automatic longint unsigned srgb_curve_q30(longint unsigned num,
                                                     longint unsigned den);
    longint unsigned one, half, a, b, lo, hi, mid;
    one  = 64'd1 << 30;
    half = 64'd1 << 29;
    if (num * 100000 <= 4045 * den)
      return (num * 200 * one + 1292 * den) / (2 * 1292 * den);
    a  = ((1000 * num + 55 * den) * 2 * one + 1055 * den) / (2 * 1055 * den);
    b  = (a * a + half) >> 30;
    lo = 0;
    hi = one;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (q30_pow5(mid) <= b) lo = mid;
      else hi = mid - 1;
    end
    return (b * lo + half) >> 30;
  endfunction

  // Nearest 8-bit sRGB code for a linear value
  function automatic logic [7:0] linear_to_code(longint unsigned v);
    int n;
    n = 0;
    for (int k = 1; k < 256; k++)
      if (enc_thr[k] <= v) n++;
    return 8'(n);
  endfunction

  // Expected output pixel for one input pixel under mode m
  function automatic rgba_t predict_cvd(mode_t m, rgba_t px);
    rgba_t   res;
    longint  lin [3];
    longint  acc;
    longint unsigned q;
    logic [7:0] code [3];
    res = px;
    if (m == MODE_ORIGINAL) return res;
    lin[0] = longint'(dec_lin[px.red]);
    lin[1] = longint'(dec_lin[px.green]);
    lin[2] = longint'(dec_lin[px.blue]);
    for (int row = 0; row < 3; row++) begin
      acc = 0;
      for (int col = 0; col < 3; col++)
        acc += longint'(mix_w[int'(m)][row][col]) * lin[col];
      // negative sums give black, overshoot clamps to full scale
      if (acc <= 0) q = 0;
      else begin
        q = (unsigned'(acc) + 8192) >> 14;
        if (q > LIN_MAX) q = LIN_MAX;
      end
      code[row] = linear_to_code(q);
    end
    res.red   = code[0];
    res.green = code[1];
    res.blue  = code[2];
    return res;
  endfunction

  // Random channel value, biased toward the extremes now and then
  function automatic logic [7:0] rand_channel();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic stim_word_t pixel_word(logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, logic [7:0] a);
    stim_word_t w;
    w.kind = WORD_PIXEL;
    w.mode = MODE_ORIGINAL;
    w.pix  = '{red: r, green: g, blue: b, alpha: a};
    return w;
  endfunction

  function automatic stim_word_t mode_word(mode_t m);
    stim_word_t w;
    w.kind = WORD_MODE;
    w.mode = m;
    w.pix  = '0;
    return w;
  endfunction

  // No random idling on either side over this stretch; the long hold-off still applies
  function automatic bit steady_stretch();
    return pix_accepted >= 900 && pix_accepted < 1250;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    mode_t phase_modes [8];
    rst           = 1'b1;
    pix_if.valid  = 1'b0;
    pix_if.red_in = '0;
    pix_if.green_in = '0;
    pix_if.blue_in  = '0;
    pix_if.alpha_in = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.mode   = MODE_ORIGINAL;
    res_if.ready  = 1'b0;
    cur_mode      = MODE_ORIGINAL;
    pix_fire      = 1'b0;
    cfg_fire      = 1'b0;
    pix_accepted  = 0;
    err_count     = 0;
    cycles        = 0;
    hold_left     = 0;
    next_hold     = 300;

    // sRGB decode table and encode thresholds, full scale 65535
    for (int i = 0; i < 256; i++)
      dec_lin[i] = (srgb_curve_q30(i, 255) * LIN_MAX + (64'd1 << 29)) >> 30;
    enc_thr[0] = 0;
    for (int k = 1; k < 256; k++)
      enc_thr[k] = (srgb_curve_q30(2 * k - 1, 510) * LIN_MAX + (64'd1 << 30) - 1) >> 30;

    // Directed: each mode with black, white, primaries and a mixed pattern.
    // Pure blue drives negative sums, pure red overshoots in tritan mode.
    phase_modes = '{MODE_ORIGINAL, MODE_PROTAN, MODE_DEUTAN, MODE_TRITAN,
                    MODE_TRITAN, MODE_ORIGINAL, MODE_PROTAN, MODE_DEUTAN};
    for (int p = 0; p < 4; p++) begin
      pending_words.push_back(mode_word(phase_modes[p]));
      pending_words.push_back(pixel_word(8'h00, 8'h00, 8'h00, 8'h00));
      pending_words.push_back(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      pending_words.push_back(pixel_word(8'hFF, 8'h00, 8'h00, 8'h55));
      pending_words.push_back(pixel_word(8'h00, 8'hFF, 8'h00, 8'hAA));
      pending_words.push_back(pixel_word(8'h00, 8'h00, 8'hFF, 8'h01));
      pending_words.push_back(pixel_word(8'h55, 8'hAA, 8'h0A, 8'h80));
    end

    // Random phases, the last few under a random mode
    for (int p = 0; p < 8; p++) begin
      if (p < 4) pending_words.push_back(mode_word(phase_modes[p + 4]));
      else pending_words.push_back(mode_word(mode_t'($urandom_range(3))));
      for (int n = 0; n < PHASE_WORDS; n++)
        pending_words.push_back(pixel_word(rand_channel(), rand_channel(),
                                           rand_channel(), rand_channel()));
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every word to go out and every result to come back
    while (pending_words.size() != 0 || pix_if.valid || cfg_if.valid ||
           expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Driver: pixel words and mode writes, updated on the falling edge
  always @(negedge clk) begin : drive_words
    logic       pv, cv;
    stim_word_t w;
    pv = pix_if.valid;
    cv = cfg_if.valid;
    if (pv && pix_fire) pv = 1'b0;
    if (cv && cfg_fire) cv = 1'b0;
    if (!rst && !pv && !cv && pending_words.size() != 0) begin
      w = pending_words[0];
      if (w.kind == WORD_MODE) begin
        // mode changes only with the pipe empty
        if (expected_pixels.size() == 0) begin
          void'(pending_words.pop_front());
          cfg_if.mode <= w.mode;
          cv = 1'b1;
        end
      end else if (steady_stretch() || $urandom_range(99) >= IDLE_PCT) begin
        void'(pending_words.pop_front());
        pix_if.red_in   <= w.pix.red;
        pix_if.green_in <= w.pix.green;
        pix_if.blue_in  <= w.pix.blue;
        pix_if.alpha_in <= w.pix.alpha;
        pv = 1'b1;
      end
    end
    pix_if.valid <= pv;
    cfg_if.valid <= cv;
  end

  // Receiver ready: random stalls plus a long hold-off every so often
  always @(negedge clk) begin : drive_ready
    logic rdy;
    if (rst) rdy = 1'b0;
    else if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (pix_accepted >= next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold += HOLD_EVERY;
      rdy = 1'b0;
    end else begin
      rdy = steady_stretch() || $urandom_range(99) >= IDLE_PCT;
    end
    res_if.ready <= rdy;
  end

  // Monitor: track mode, predict accepted pixels, check results
  always @(posedge clk) begin : watch_words
    rgba_t px, got, want;
    pix_fire <= !rst && pix_if.valid && pix_if.ready;
    cfg_fire <= !rst && cfg_if.valid && cfg_if.ready;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) cur_mode = mode_t'(cfg_if.mode);
      if (pix_if.valid && pix_if.ready) begin
        px = '{red: pix_if.red_in, green: pix_if.green_in,
               blue: pix_if.blue_in, alpha: pix_if.alpha_in};
        expected_pixels.push_back(predict_cvd(cur_mode, px));
        pix_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        got = '{red: res_if.red_out, green: res_if.green_out,
                blue: res_if.blue_out, alpha: res_if.alpha_out};
        if (expected_pixels.size() == 0) begin
          err_count++;
          $display("%0t: result word with nothing expected, actual %h", $time, got);
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out", want.red, got.red);
          check_field("green_out", want.green, got.green);
          check_field("blue_out", want.blue, got.blue);
          check_field("alpha_out", want.alpha, got.alpha);
        end
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+design
design/cvd_pkg.sv
design/cvd_pixel_if.sv
design/cvd_result_if.sv
design/cvd_cfg_if.sv
design/cvd_decode.sv
design/cvd_mix.sv
design/cvd_encode.sv
design/color_vision_deficiency_pixel_top.sv
design/cvd_checker.sv
bench/color_vision_deficiency_pixel_top_tb.sv
